FILE: hdl/stngs_pkg.sv
package stngs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int VALUE_W     = 31;
    localparam int POS_W       = 16;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - POS_W;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;   // append the accepted word
        logic start;  // open a search over [0, count)
        logic step;   // one halving step, or the final fetch
        logic emit;   // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic active;    // search interval still non-empty
        logic out_free;  // output register can take a word
    } t_dp_sts;

endpackage

FILE: hdl/stngs_ram.sv
module stngs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/stngs_ctrl.sv
module stngs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_kind,
    output logic              o_in_ready,
    input  stngs_pkg::t_dp_sts i_sts,
    output stngs_pkg::t_dp_cmd o_cmd
);

    stngs_pkg::t_state r_state;
    stngs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stngs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            stngs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_kind == stngs_pkg::KIND_QUERY) begin
                        o_cmd.start = 1'b1;
                        n_state     = stngs_pkg::ST_SEARCH;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            stngs_pkg::ST_SEARCH: begin
                // the last step issues the fetch of the selected entry
                o_cmd.step = 1'b1;
                if (!i_sts.active) begin
                    n_state = stngs_pkg::ST_RESULT;
                end
            end
            stngs_pkg::ST_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = stngs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stngs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/stngs_dp.sv
module stngs_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  stngs_pkg::t_dp_cmd                  i_cmd,
    output stngs_pkg::t_dp_sts                  o_sts,
    input  logic [stngs_pkg::VALUE_W-1:0]       i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [stngs_pkg::OUT_TDATA_W-1:0]   o_out_data,
    output logic                                o_out_found
);

    localparam int CW = stngs_pkg::CNT_W;
    localparam int AW = stngs_pkg::ADDR_W;
    localparam int VW = stngs_pkg::VALUE_W;
    localparam int PW = stngs_pkg::POS_W;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_mid, n_mid;
    logic [VW-1:0] r_q;

    logic          r_out_valid;
    logic [VW-1:0] r_out_value;
    logic [PW-1:0] r_out_pos;
    logic          r_out_found;

    logic          full;
    logic          active;
    logic          gt;
    logic [CW:0]   sum_gt;
    logic [CW:0]   sum_le;
    logic [CW-1:0] mid_gt;
    logic [CW-1:0] mid_le;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_addr;
    logic [VW-1:0] ram_rdata;
    logic          res_found;

    assign full   = (r_count == CW'(stngs_pkg::TABLE_DEPTH));
    assign active = (r_lo < r_hi);
    assign gt     = (ram_rdata > r_q);

    // both candidate midpoints in parallel with the compare
    assign sum_gt = {1'b0, r_lo} + {1'b0, r_mid};
    assign sum_le = {1'b0, r_mid} + {1'b0, r_hi} + (CW+1)'(1);
    assign mid_gt = sum_gt[CW:1];
    assign mid_le = sum_le[CW:1];

    always_comb begin
        n_count  = r_count;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        ram_addr = r_count[AW-1:0];
        if (i_cmd.load) begin
            ram_we = !full;
            if (!full) begin
                n_count = r_count + CW'(1);
            end
        end else if (i_cmd.start) begin
            ram_re   = 1'b1;
            n_lo     = '0;
            n_hi     = r_count;
            n_mid    = r_count >> 1;
            ram_addr = n_mid[AW-1:0];
        end else if (i_cmd.step) begin
            ram_re = 1'b1;
            if (active) begin
                if (gt) begin
                    n_hi  = r_mid;
                    n_mid = mid_gt;
                end else begin
                    n_lo  = r_mid + CW'(1);
                    n_mid = mid_le;
                end
                ram_addr = n_mid[AW-1:0];
            end else begin
                // fetch the selected entry
                ram_addr = r_lo[AW-1:0];
            end
        end
    end

    assign res_found = (r_lo < r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mid <= n_mid;
        if (i_cmd.start) begin
            r_q <= i_value;
        end
        if (i_cmd.emit) begin
            r_out_found <= res_found;
            r_out_value <= res_found ? ram_rdata : '0;
            r_out_pos   <= res_found ? PW'(r_lo) : '0;
        end
    end

    stngs_ram #(
        .WIDTH (VW),
        .DEPTH (stngs_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_value),
        .o_rdata (ram_rdata)
    );

    assign o_sts.active   = active;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_found    = r_out_found;
    assign o_out_data     = {{stngs_pkg::OUT_PAD_W{1'b0}}, r_out_pos, r_out_value};

`ifndef SYNTHESIS
    a_lo_le_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo <= r_hi)
        else $error("search interval inverted");

    a_hi_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hi <= r_count)
        else $error("search bound beyond entry count");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(stngs_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && full) |=> $stable(r_count))
        else $error("load into a full table changed the count");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a pending word");
`endif

endmodule

FILE: hdl/sorted_table_next_greater_search.sv
// Keeps an ascending table of up to TABLE_DEPTH 31-bit values and, for each
// query word, returns the first entry strictly greater than the query number
// and its index. A load word (tuser = 0) appends tdata to the end of the table
// and gives no result; loads into a full table are dropped and order is never
// checked. A query word (tuser = 1) runs a binary search: one halving step per
// cycle, each step comparing the word read from the single-port table memory,
// followed by one fetch of the selected entry; the memory read port sets that
// pace. The entry is moved into the result register once that register is
// free, and the next word is taken after that. One query is in flight at a
// time, and no word is taken while it runs. The result sits in an output
// register, so the next word can be accepted while it waits for the consumer.
// When no greater entry exists, found is 0 and value and position read zero.
// The table holds whatever was written; there is no clearing pass after reset.
module sorted_table_next_greater_search (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [stngs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [30:0] value, [31] zero
    input  logic                                s_axis_tuser,  // [0] kind: 0 load, 1 query
    // master side
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [stngs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [30:0] next_value,
                                                               // [46:31] position, [47] zero
    output logic                                m_axis_tuser   // [0] found
);

    stngs_pkg::t_dp_cmd cmd;
    stngs_pkg::t_dp_sts sts;

    // sequencing: accept, halving steps, fetch, hand-off to output
    stngs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // table memory, search bounds, entry count and output register
    stngs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_value     (s_axis_tdata[stngs_pkg::VALUE_W-1:0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_found (m_axis_tuser)
    );

endmodule

FILE: tb/tb_sorted_table_next_greater_search.sv
module tb_sorted_table_next_greater_search;

    localparam int VALUE_W      = stngs_pkg::VALUE_W;
    localparam int POS_W        = stngs_pkg::POS_W;
    localparam int TABLE_DEPTH  = stngs_pkg::TABLE_DEPTH;
    localparam int IN_TDATA_W   = stngs_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W  = stngs_pkg::OUT_TDATA_W;

    localparam int RUN_LIMIT    = 200_000;  // far above ~550 words at the slowest pacing
    localparam int DRAIN_CYCLES = 40;       // drain time after the last result word
    localparam int RANDOM_WORDS = 510;
    localparam int SWAP_AT      = 200;
    localparam int FREE_AT      = 400;
    localparam int HOLD_AT      = 460;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
    localparam longint ASCEND_CEIL = 64'h7FFF_FFFF - 2 * TABLE_DEPTH;

    typedef enum logic [1:0] {
        PACE_SLOW_SEND,
        PACE_SLOW_TAKE,
        PACE_FREE
    } t_pace;

    typedef struct {
        stngs_pkg::t_kind   kind;
        logic [VALUE_W-1:0] value;
        t_pace              pace;
    } t_word;

    typedef struct packed {
        logic [VALUE_W-1:0] next_value;
        logic               found;
        logic [POS_W-1:0]   position;
    } t_successor;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [30:0] value, [31] zero
    logic                   s_axis_tuser  = 1'b0; // [0] kind
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [30:0] next_value, [46:31] position, [47] zero
    logic                   m_axis_tuser;        // [0] found

    sorted_table_next_greater_search uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor state
    logic [VALUE_W-1:0] prime_table [0:TABLE_DEPTH-1];
    int unsigned        prime_count = 0;
    t_successor         successor_queue [$];

    // stimulus state
    t_word              word_queue [$];
    logic [VALUE_W-1:0] ascend_vals [$];
    longint             last_ascending = 0;
    int unsigned        queued_total = 0;

    t_pace       cur_pace = PACE_SLOW_SEND;
    int unsigned words_presented = 0;
    bit          in_word_taken = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned send_idle_pct(input t_pace p);
        case (p)
            PACE_SLOW_SEND: return 22;
            PACE_SLOW_TAKE: return 56;
            default:        return 0;
        endcase
    endfunction

    function automatic int unsigned take_idle_pct(input t_pace p);
        case (p)
            PACE_SLOW_SEND: return 56;
            PACE_SLOW_TAKE: return 22;
            default:        return 0;
        endcase
    endfunction

    // Upper-bound binary search over the entries in use; same halving steps as the block,
    // so an unordered table selects the same entry.
    function automatic t_successor find_successor(input logic [VALUE_W-1:0] q);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        t_successor  r;
        lo = 0;
        hi = prime_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (prime_table[mid] > q) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        r = '0;
        if (lo < prime_count) begin
            r.next_value = prime_table[lo];
            r.found      = 1'b1;
            r.position   = lo[POS_W-1:0];
        end
        return r;
    endfunction

    task automatic absorb_word(input stngs_pkg::t_kind k, input logic [VALUE_W-1:0] v);
        if (k == stngs_pkg::KIND_LOAD) begin
            // drop loads into a full table
            if (prime_count < TABLE_DEPTH) begin
                prime_table[prime_count] = v;
                prime_count++;
            end
        end else begin
            successor_queue.push_back(find_successor(v));
        end
    endtask

    task automatic queue_word(input stngs_pkg::t_kind k, input logic [VALUE_W-1:0] v);
        t_word w;
        w.kind  = k;
        w.value = v;
        w.pace  = (queued_total < SWAP_AT) ? PACE_SLOW_SEND :
                  (queued_total < FREE_AT) ? PACE_SLOW_TAKE : PACE_FREE;
        word_queue.push_back(w);
        queued_total++;
    endtask

    task automatic queue_ascending(input longint v);
        queue_word(stngs_pkg::KIND_LOAD, v[VALUE_W-1:0]);
        ascend_vals.push_back(v[VALUE_W-1:0]);
        last_ascending = v;
    endtask

    // Mostly numbers at or next to a loaded entry, some anywhere, a few at the extremes.
    function automatic logic [VALUE_W-1:0] pick_query();
        int unsigned        r;
        logic [VALUE_W-1:0] base;
        r = $urandom_range(99);
        if (r < 10) return $urandom_range(1) ? '0 : VALUE_MAX;
        if (r < 40 || ascend_vals.size() == 0) return VALUE_W'($urandom);
        base = ascend_vals[$urandom_range(ascend_vals.size() - 1)];
        case ($urandom_range(2))
            0:       return base - 1'b1;
            1:       return base;
            default: return base + 1'b1;
        endcase
    endfunction

    task automatic report(input string field, input longint want, input longint got);
        mismatches++;
        $display("%0t %s mismatch: expected %h, actual %h", $time, field, want, got);
    endtask

    // Present the head of the queue at the falling edge; hold it until taken.
    always @(negedge i_clk) begin : drive_words
        t_word w;
        if (i_rst_n && (!s_axis_tvalid || in_word_taken)) begin
            if (word_queue.size() != 0 &&
                $urandom_range(99) >= send_idle_pct(word_queue[0].pace)) begin
                w = word_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {1'b0, w.value};
                s_axis_tuser  <= w.kind;
                cur_pace = w.pace;
                words_presented++;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Consumer side, with one long hold-off so the block backs up into its input.
    always @(negedge i_clk) begin : drive_ready
        if (!hold_done && words_presented >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= take_idle_pct(cur_pace));
        end
    end

    always @(posedge i_clk) begin : watch_ports
        t_successor want;
        t_successor got;
        in_word_taken = s_axis_tvalid && s_axis_tready;
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("status: fail");
            $finish;
        end else if (i_rst_n) begin
            if (in_word_taken) begin
                absorb_word(stngs_pkg::t_kind'(s_axis_tuser), s_axis_tdata[VALUE_W-1:0]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.next_value = m_axis_tdata[VALUE_W-1:0];
                got.position   = m_axis_tdata[VALUE_W+POS_W-1:VALUE_W];
                got.found      = m_axis_tuser;
                if (successor_queue.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected result word: expected none, actual %h/%h",
                             $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    want = successor_queue.pop_front();
                    if (got.next_value !== want.next_value)
                        report("next_value", want.next_value, got.next_value);
                    if (got.found !== want.found)
                        report("found", want.found, got.found);
                    if (got.position !== want.position)
                        report("position", want.position, got.position);
                    if (m_axis_tdata[OUT_TDATA_W-1:VALUE_W+POS_W] !== '0)
                        report("pad", 0, m_axis_tdata[OUT_TDATA_W-1:VALUE_W+POS_W]);
                end
            end
        end
    end

    initial begin
        longint      nxt;
        int unsigned pick;

        // empty table, then a short ordered table with a duplicate
        queue_word(stngs_pkg::KIND_QUERY, '0);
        queue_word(stngs_pkg::KIND_QUERY, VALUE_MAX);
        queue_ascending(0);
        queue_ascending(2);
        queue_ascending(3);
        queue_ascending(5);
        queue_ascending(7);
        queue_ascending(11);
        queue_ascending(11);
        queue_word(stngs_pkg::KIND_QUERY, VALUE_W'(0));
        queue_word(stngs_pkg::KIND_QUERY, VALUE_W'(1));
        queue_word(stngs_pkg::KIND_QUERY, VALUE_W'(2));
        queue_word(stngs_pkg::KIND_QUERY, VALUE_W'(4));
        queue_word(stngs_pkg::KIND_QUERY, VALUE_W'(10));
        queue_word(stngs_pkg::KIND_QUERY, VALUE_W'(11));
        queue_word(stngs_pkg::KIND_QUERY, VALUE_MAX);
        // out-of-order entry at the tail
        queue_word(stngs_pkg::KIND_LOAD, VALUE_W'(1));
        queue_word(stngs_pkg::KIND_QUERY, VALUE_W'(0));
        queue_word(stngs_pkg::KIND_QUERY, VALUE_W'(6));

        // ascending loads with mixed gaps, queries, and a little unordered noise
        repeat (RANDOM_WORDS) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                nxt = last_ascending + (($urandom_range(3) == 0) ? $urandom_range(1, 4)
                                                                 : $urandom_range(1, 1 << 24));
                if (nxt > ASCEND_CEIL) nxt = last_ascending + 1;
                queue_ascending(nxt);
            end else if (pick < 44) begin
                queue_word(stngs_pkg::KIND_LOAD, VALUE_W'($urandom));
            end else begin
                queue_word(stngs_pkg::KIND_QUERY, pick_query());
            end
        end

        // unordered loads at the extremes, then queries around the top of the table
        queue_word(stngs_pkg::KIND_LOAD, '0);
        queue_word(stngs_pkg::KIND_LOAD, VALUE_MAX);
        queue_word(stngs_pkg::KIND_LOAD, VALUE_W'($urandom));
        queue_word(stngs_pkg::KIND_QUERY, '0);
        queue_word(stngs_pkg::KIND_QUERY, VALUE_MAX);
        queue_word(stngs_pkg::KIND_QUERY, VALUE_W'(last_ascending));
        queue_word(stngs_pkg::KIND_QUERY, VALUE_W'(last_ascending - 1));
        repeat (16) queue_word(stngs_pkg::KIND_QUERY, pick_query());

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (word_queue.size() != 0 || s_axis_tvalid || successor_queue.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (successor_queue.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
